// ===== rtl/core/bitmap_frame_allocator_top_assert.svh =====
// Assertion macros for the allocator RTL; only bfa_ctrl includes them.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfa: assertion failed");

`endif

// ===== rtl/core/bfa_pkg.sv =====
// Shared types and constants of the bitmap frame allocator.
// No dependencies; every other file of the block but the assertion header uses it.
`default_nettype none

package bfa_pkg;

    localparam int C_FRAME_W   = 20;
    localparam int C_COUNT_W   = 11;
    localparam int C_KIND_W    = 2;
    localparam int C_CFG_IDX_W = 2;
    localparam int C_IDX_W     = 11;  // pool index, pool never exceeds 2047 frames
    localparam int C_WIDX_W    = 6;   // word part of a pool index
    localparam int C_WORD_W    = 32;
    localparam int C_MAP_FRAMES = 1024;

    typedef enum logic [C_KIND_W-1:0] {
        KIND_INIT    = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_MARK    = 2'd3
    } t_kind;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_BASE_FRAME  = 2'd0,
        REG_FRAME_COUNT = 2'd1,
        REG_INFO_FRAME  = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_REL_RD,
        S_REL_WR,
        S_MSET,
        S_MARK,
        S_DONE
    } t_state;

    // Pool geometry derived from the configuration registers.
    typedef struct packed {
        logic [C_FRAME_W-1:0] base;
        logic [C_IDX_W-1:0]   size;
        logic                 empty;
        logic [C_WIDX_W-1:0]  last_w;
        logic [C_WORD_W-1:0]  last_mask;
        logic                 info_in;
        logic [C_IDX_W-1:0]   info_idx;
    } t_pool;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [C_WORD_W-1:0] wr_data;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== rtl/core/bfa_if.sv =====
// Handshake channels of the allocator: request, response and register write.
// Payload widths come from bfa_pkg.
`default_nettype none

interface bfa_req_if;
    logic                           valid;
    logic                           ready;
    logic [bfa_pkg::C_KIND_W-1:0]   kind;
    logic [bfa_pkg::C_FRAME_W-1:0]  frame;
    logic [bfa_pkg::C_COUNT_W-1:0]  count;
    modport source (output valid, output kind, output frame, output count, input ready);
    modport sink   (input valid, input kind, input frame, input count, output ready);
endinterface

interface bfa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bfa_pkg::C_FRAME_W-1:0]  alloc_frame;
    logic                           ok;
    modport source (output valid, output alloc_frame, output ok, input ready);
    modport sink   (input valid, input alloc_frame, input ok, output ready);
endinterface

interface bfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bfa_pkg::C_CFG_IDX_W-1:0] index;
    logic [bfa_pkg::C_FRAME_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfa_cfg.sv =====
// Configuration registers and the pool geometry derived from them.
// Depends on bfa_pkg and bfa_cfg_if.
`default_nettype none

module bfa_cfg #(
    parameter int MAP_FRAMES = bfa_pkg::C_MAP_FRAMES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bfa_cfg_if.sink             i_cfg,
    output bfa_pkg::t_pool      o_pool
);
    import bfa_pkg::*;

    logic [C_FRAME_W-1:0] r_base, n_base;
    logic [C_COUNT_W-1:0] r_fcnt, n_fcnt;
    logic [C_FRAME_W-1:0] r_info, n_info;

    logic [C_IDX_W-1:0]   size;
    logic [C_IDX_W-1:0]   size_m1;
    logic [C_FRAME_W-1:0] info_eff;
    logic [C_FRAME_W-1:0] info_diff;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_base = r_base;
        n_fcnt = r_fcnt;
        n_info = r_info;
        if (i_cfg.valid) begin
            case (t_reg'(i_cfg.index))
                REG_BASE_FRAME:  n_base = i_cfg.data;
                REG_FRAME_COUNT: n_fcnt = i_cfg.data[C_COUNT_W-1:0];
                REG_INFO_FRAME:  n_info = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_fcnt <= '0;
            r_info <= '0;
        end else begin
            r_base <= n_base;
            r_fcnt <= n_fcnt;
            r_info <= n_info;
        end
    end

    // Clip the pool to the map.
    assign size    = (32'(r_fcnt) > MAP_FRAMES) ? C_IDX_W'(MAP_FRAMES) : r_fcnt;
    assign size_m1 = size - 1'b1;

    assign info_eff  = (r_info == '0) ? r_base : r_info;
    assign info_diff = info_eff - r_base;

    always_comb begin
        o_pool.base      = r_base;
        o_pool.size      = size;
        o_pool.empty     = (size == '0);
        o_pool.last_w    = size_m1[C_IDX_W-1:5];
        o_pool.last_mask = (size[4:0] == 5'd0) ? {C_WORD_W{1'b1}}
                         : ((C_WORD_W'(1) << size[4:0]) - 1'b1);
        o_pool.info_in   = (info_eff >= r_base) && (info_diff < C_FRAME_W'(size));
        o_pool.info_idx  = info_diff[C_IDX_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bfa_map_ram.sv =====
// Used-bit map storage: one 32-bit word per 32 frames, one write and one
// registered read port. Depends on bfa_pkg.
`default_nettype none

module bfa_map_ram #(
    parameter int WORDS = bfa_pkg::C_MAP_FRAMES / bfa_pkg::C_WORD_W,
    parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic                           i_clk,
    input  wire bfa_pkg::t_ram_req              i_req,
    input  wire logic [AW-1:0]                  i_rd_addr,
    input  wire logic [AW-1:0]                  i_wr_addr,
    output      logic [bfa_pkg::C_WORD_W-1:0]   o_rd_data
);
    import bfa_pkg::*;

    logic [C_WORD_W-1:0] mem [WORDS];
    logic [C_WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/bfa_ctrl.sv =====
// Sequencer of the allocator: read-modify-write over the map words, the
// clearing sweep and the output register. Depends on bfa_pkg, bfa_if and the assertion header.
`default_nettype none
`include "bitmap_frame_allocator_top_assert.svh"

module bfa_ctrl #(
    parameter int MAP_FRAMES = bfa_pkg::C_MAP_FRAMES,
    parameter int WORDS      = (MAP_FRAMES + bfa_pkg::C_WORD_W - 1) / bfa_pkg::C_WORD_W,
    parameter int AW         = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bfa_pkg::t_pool                 i_pool,
    bfa_req_if.sink                             i_req,
    bfa_rsp_if.source                           o_rsp,
    output      bfa_pkg::t_ram_req              o_ram,
    output      logic [AW-1:0]                  o_rd_addr,
    output      logic [AW-1:0]                  o_wr_addr,
    input  wire logic [bfa_pkg::C_WORD_W-1:0]   i_rd_data
);
    import bfa_pkg::*;

    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [C_WIDX_W:0]     r_raddr, n_raddr;
    logic [C_WIDX_W-1:0]   r_endw, n_endw;
    logic                  r_pvld, n_pvld;
    logic [C_WIDX_W-1:0]   r_paddr, n_paddr;
    logic [C_IDX_W-1:0]    r_idx, n_idx;
    logic [C_IDX_W-1:0]    r_lo, n_lo;
    logic [C_IDX_W-1:0]    r_last, n_last;
    logic [C_FRAME_W-1:0]  r_frame, n_frame;
    logic [C_COUNT_W-1:0]  r_count, n_count;
    logic [C_FRAME_W-1:0]  r_res_fno, n_res_fno;
    logic                  r_res_ok, n_res_ok;
    logic                  r_ovld, n_ovld;
    logic [C_FRAME_W-1:0]  r_ofno, n_ofno;
    logic                  r_ook, n_ook;

    logic [C_WORD_W-1:0]   free_bits;
    logic [C_WORD_W-1:0]   lowest;
    logic [4:0]            bitno;
    logic [C_WORD_W-1:0]   mask_lo;
    logic [C_WORD_W-1:0]   mask_hi;
    logic [C_WORD_W-1:0]   init_word;
    logic [C_FRAME_W-1:0]  rel_diff;
    logic                  rel_in;
    logic                  issue;
    logic                  in_ready;
    logic [C_FRAME_W-1:0]  m_lo;
    logic [C_FRAME_W:0]    m_hi_a;
    logic [C_FRAME_W:0]    m_pe;
    logic [C_FRAME_W:0]    m_hi;
    logic [C_IDX_W-1:0]    m_lo_i;
    logic [C_IDX_W-1:0]    m_last_i;

    // Lowest free bit of the word just read, limited to the pool.
    assign free_bits = ~i_rd_data & ((r_paddr == i_pool.last_w) ? i_pool.last_mask
                                                                : {C_WORD_W{1'b1}});
    assign lowest    = free_bits & (~free_bits + 1'b1);

    always_comb begin
        bitno = '0;
        for (int j = 0; j < C_WORD_W; j++) begin
            if (lowest[j]) begin
                bitno = bitno | 5'(j);
            end
        end
    end

    // Bits of the current word that fall inside the mark range.
    assign mask_lo = (r_paddr == r_lo[C_IDX_W-1:5]) ? ({C_WORD_W{1'b1}} << r_lo[4:0])
                                                     : {C_WORD_W{1'b1}};
    assign mask_hi = (r_paddr == r_last[C_IDX_W-1:5])
                   ? ({C_WORD_W{1'b1}} >> (5'd31 - r_last[4:0])) : {C_WORD_W{1'b1}};

    assign init_word = (i_pool.info_in && (r_addr == AW'(i_pool.info_idx[C_IDX_W-1:5])))
                     ? (C_WORD_W'(1) << i_pool.info_idx[4:0]) : '0;

    assign rel_diff = i_req.frame - i_pool.base;
    assign rel_in   = (i_req.frame >= i_pool.base) && (rel_diff < C_FRAME_W'(i_pool.size));

    // Mark range clipped to the pool, taken from the held request.
    assign m_lo     = (r_frame < i_pool.base) ? i_pool.base : r_frame;
    assign m_hi_a   = (C_FRAME_W+1)'(r_frame) + (C_FRAME_W+1)'(r_count);
    assign m_pe     = (C_FRAME_W+1)'(i_pool.base) + (C_FRAME_W+1)'(i_pool.size);
    assign m_hi     = (m_hi_a < m_pe) ? m_hi_a : m_pe;
    assign m_lo_i   = C_IDX_W'(m_lo - i_pool.base);
    assign m_last_i = C_IDX_W'(m_hi - (C_FRAME_W+1)'(i_pool.base)) - 1'b1;

    assign issue = (r_raddr <= {1'b0, r_endw});

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_raddr   = r_raddr;
        n_endw    = r_endw;
        n_pvld    = r_pvld;
        n_paddr   = r_paddr;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_last    = r_last;
        n_frame   = r_frame;
        n_count   = r_count;
        n_res_fno = r_res_fno;
        n_res_ok  = r_res_ok;
        n_ovld    = r_ovld;
        n_ofno    = r_ofno;
        n_ook     = r_ook;
        in_ready  = 1'b0;
        o_ram.rd_en   = 1'b0;
        o_ram.wr_en   = 1'b0;
        o_ram.wr_data = i_rd_data;
        o_rd_addr = AW'(r_raddr[C_WIDX_W-1:0]);
        o_wr_addr = AW'(r_paddr);

        if (o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_CLEAR, S_INIT: begin
                o_ram.wr_en   = 1'b1;
                o_wr_addr     = r_addr;
                o_ram.wr_data = (r_state == S_INIT) ? init_word : '0;
                if (r_addr == LAST_WORD) begin
                    n_res_ok = i_pool.info_in;
                    n_state  = (r_state == S_INIT) ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    n_res_fno = '0;
                    n_res_ok  = 1'b0;
                    n_pvld    = 1'b0;
                    n_raddr   = '0;
                    case (t_kind'(i_req.kind))
                        KIND_INIT: begin
                            n_addr  = '0;
                            n_state = S_INIT;
                        end
                        KIND_ALLOC: begin
                            n_endw  = i_pool.last_w;
                            n_state = i_pool.empty ? S_DONE : S_SCAN;
                        end
                        KIND_RELEASE: begin
                            n_idx   = rel_diff[C_IDX_W-1:0];
                            n_state = rel_in ? S_REL_RD : S_DONE;
                        end
                        default: begin
                            n_frame = i_req.frame;
                            n_count = i_req.count;
                            n_state = S_MSET;
                        end
                    endcase
                end
            end
            S_SCAN, S_MARK: begin
                // Read one word ahead while the previous one is written back.
                if (issue) begin
                    o_ram.rd_en = 1'b1;
                    n_raddr     = r_raddr + 1'b1;
                end
                n_pvld  = issue;
                n_paddr = r_raddr[C_WIDX_W-1:0];
                if (r_pvld) begin
                    if (r_state == S_MARK) begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_data = i_rd_data | (mask_lo & mask_hi);
                        if (r_paddr == r_endw) begin
                            n_state = S_DONE;
                        end
                    end else if (free_bits != '0) begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_data = i_rd_data | lowest;
                        n_res_fno = i_pool.base + C_FRAME_W'({r_paddr, bitno});
                        n_res_ok  = 1'b1;
                        n_state   = S_DONE;
                    end else if (r_paddr == r_endw) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_REL_RD: begin
                o_ram.rd_en = 1'b1;
                o_rd_addr   = AW'(r_idx[C_IDX_W-1:5]);
                n_state     = S_REL_WR;
            end
            S_REL_WR: begin
                o_ram.wr_en   = 1'b1;
                o_wr_addr     = AW'(r_idx[C_IDX_W-1:5]);
                o_ram.wr_data = i_rd_data & ~(C_WORD_W'(1) << r_idx[4:0]);
                n_res_ok      = 1'b1;
                n_state       = S_DONE;
            end
            S_MSET: begin
                if ((C_FRAME_W+1)'(m_lo) < m_hi) begin
                    n_lo     = m_lo_i;
                    n_last   = m_last_i;
                    n_raddr  = {1'b0, m_lo_i[C_IDX_W-1:5]};
                    n_endw   = m_last_i[C_IDX_W-1:5];
                    n_pvld   = 1'b0;
                    n_res_ok = 1'b1;
                    n_state  = S_MARK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up.
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld  = 1'b1;
                    n_ofno  = r_res_fno;
                    n_ook   = r_res_ok;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pvld  <= n_pvld;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr   <= n_raddr;
        r_endw    <= n_endw;
        r_paddr   <= n_paddr;
        r_idx     <= n_idx;
        r_lo      <= n_lo;
        r_last    <= n_last;
        r_frame   <= n_frame;
        r_count   <= n_count;
        r_res_fno <= n_res_fno;
        r_res_ok  <= n_res_ok;
        r_ofno    <= n_ofno;
        r_ook     <= n_ook;
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_ovld;
    assign o_rsp.alloc_frame = r_ofno;
    assign o_rsp.ok          = r_ook;

    `BFA_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, o_ram.rd_en && o_ram.wr_en, o_rd_addr != o_wr_addr)
    `BFA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_req.valid && in_ready, !in_ready)
    `BFA_ASSERT_IMP(a_scan_wr_has_data, i_clk, i_rst_n, o_ram.wr_en && (r_state == S_SCAN || r_state == S_MARK), r_pvld)

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_frame_allocator_top.sv =====
// Bitmap first-fit page frame allocator. After reset the block sweeps the
// used-bit map clear, one word per cycle, and takes no request until that is
// done; register writes are taken at any time. One request is worked at a
// time through a single-port-write, one-read map RAM. An init request makes a
// full sweep of the map. An allocate request scans the map words in order up
// to the first free frame; the word scan is pipelined, one RAM read per cycle.
// A release reads the word and writes it back. A mark reads and writes back
// each map word the range touches. A mark outside the pool, a release outside
// the pool or an allocate on an empty pool leaves the map untouched. The result
// leaves through an output register, so the next request is taken while it
// waits.
// Depends on bfa_pkg, bfa_if, bfa_cfg, bfa_map_ram and bfa_ctrl.
`default_nettype none

module bitmap_frame_allocator_top #(
    parameter int MAP_FRAMES = bfa_pkg::C_MAP_FRAMES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bfa_cfg_if.sink     i_cfg,
    bfa_req_if.sink     i_req,
    bfa_rsp_if.source   o_rsp
);
    import bfa_pkg::*;

    localparam int WORDS = (MAP_FRAMES + C_WORD_W - 1) / C_WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_pool               pool;
    t_ram_req            ram_req;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [C_WORD_W-1:0] rd_data;

    bfa_cfg #(
        .MAP_FRAMES (MAP_FRAMES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_pool  (pool)
    );

    bfa_map_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_rd_data (rd_data)
    );

    bfa_ctrl #(
        .MAP_FRAMES (MAP_FRAMES),
        .WORDS      (WORDS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pool    (pool),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_ram     (ram_req),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .i_rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== sim/bfa_alloc_checker.sv =====
// Scoreboard for the bitmap frame allocator: watches the register, request and
// response channels, keeps its own used-frame map and checks every result beat.
// Depends on bfa_pkg and the channel interfaces of bfa_if.
module bfa_alloc_checker #(
    parameter int MAP_FRAMES = bfa_pkg::C_MAP_FRAMES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfa_cfg_if   i_cfg,
    bfa_req_if   i_req,
    bfa_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    import bfa_pkg::*;

    typedef struct packed {
        logic [C_FRAME_W-1:0] alloc_frame;
        logic                 ok;
    } t_grant;

    logic [MAP_FRAMES-1:0] used_bits;
    logic [C_FRAME_W-1:0]  base_frame_q;
    logic [C_COUNT_W-1:0]  frame_count_q;
    logic [C_FRAME_W-1:0]  info_frame_q;
    t_grant                grant_q[$];

    task automatic report_mismatch(string what);
        $display("[%0t] allocator mismatch: %s", $time, what);
        o_errors++;
    endtask

    // Apply one request to the local map and return the grant it should produce.
    function automatic t_grant predict_grant(t_kind kind, logic [C_FRAME_W-1:0] frame,
                                             logic [C_COUNT_W-1:0] count);
        t_grant          g;
        longint unsigned pool;
        longint unsigned pb;
        longint unsigned info;
        longint unsigned lo;
        longint unsigned hi;
        g    = '0;
        pb   = base_frame_q;
        pool = (frame_count_q > MAP_FRAMES) ? MAP_FRAMES : frame_count_q;
        case (kind)
            KIND_INIT: begin
                info = (info_frame_q == '0) ? pb : info_frame_q;
                used_bits = '0;
                if (info >= pb && info < pb + pool) begin
                    used_bits[info - pb] = 1'b1;
                    g.ok = 1'b1;
                end
            end
            KIND_ALLOC: begin
                for (longint unsigned i = 0; i < pool; i++) begin
                    if (!g.ok && !used_bits[i]) begin
                        used_bits[i] = 1'b1;
                        g.alloc_frame = C_FRAME_W'(pb + i);
                        g.ok = 1'b1;
                    end
                end
            end
            KIND_RELEASE: begin
                if (frame >= pb && frame < pb + pool) begin
                    used_bits[frame - pb] = 1'b0;
                    g.ok = 1'b1;
                end
            end
            default: begin
                // Clip the run to the pool; no wrap at the top of the frame space.
                lo = frame;
                hi = lo + count;
                if (lo < pb)
                    lo = pb;
                if (hi > pb + pool)
                    hi = pb + pool;
                for (longint unsigned f = lo; f < hi; f++) begin
                    used_bits[f - pb] = 1'b1;
                    g.ok = 1'b1;
                end
            end
        endcase
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            used_bits     = '0;
            base_frame_q  = '0;
            frame_count_q = '0;
            info_frame_q  = '0;
            grant_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_BASE_FRAME:  base_frame_q  = i_cfg.data;
                    REG_FRAME_COUNT: frame_count_q = i_cfg.data[C_COUNT_W-1:0];
                    REG_INFO_FRAME:  info_frame_q  = i_cfg.data;
                    default: ;
                endcase
            end
            // Retire the result beat before queuing this edge's request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result frame %05h ok %0d with nothing expected",
                                              i_rsp.alloc_frame, i_rsp.ok));
                end else begin
                    want = grant_q.pop_front();
                    o_checked++;
                    if (i_rsp.alloc_frame !== want.alloc_frame)
                        report_mismatch($sformatf("alloc_frame %05h, expected %05h",
                                                  i_rsp.alloc_frame, want.alloc_frame));
                    if (i_rsp.ok !== want.ok)
                        report_mismatch($sformatf("ok %0d, expected %0d (alloc_frame %05h)",
                                                  i_rsp.ok, want.ok, want.alloc_frame));
                end
            end
            if (i_req.valid && i_req.ready)
                grant_q.push_back(predict_grant(t_kind'(i_req.kind), i_req.frame, i_req.count));
            o_pending <= grant_q.size();
        end
    end

endmodule

// ===== sim/bitmap_frame_allocator_top_tb.sv =====
// Top of the allocator regression: clock, reset, register and request stimulus,
// response back-pressure and the verdict. Depends on bfa_pkg, bfa_if,
// bitmap_frame_allocator_top and bfa_alloc_checker.
module bitmap_frame_allocator_top_tb;
    import bfa_pkg::*;

    localparam int C_CYCLE_LIMIT   = 500000;
    localparam int C_RANDOM_PHASES = 6;
    localparam int C_PHASE_ITEMS   = 230;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   checked;

    int                   sent_total;
    int                   kind_sent[4];
    int                   settings;
    logic [C_FRAME_W-1:0] pool_base;
    int                   pool_frames;

    bfa_cfg_if cfg_ch();
    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    bitmap_frame_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bfa_alloc_checker u_scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_ch),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < C_CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("run exceeded %0d cycles", C_CYCLE_LIMIT);
        $display("bitmap_frame_allocator_top regression: fail");
        $finish;
    end

    // Random wait with a stretch of back-to-back beats every third block of 64.
    function automatic int pick_wait(int beat);
        if ((beat / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic write_reg(t_reg index, logic [C_FRAME_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic configure(logic [C_FRAME_W-1:0] base, logic [C_COUNT_W-1:0] frames,
                             logic [C_FRAME_W-1:0] info, bit poke_unused);
        if (poke_unused)
            write_reg(REG_UNUSED, '1);
        write_reg(REG_BASE_FRAME, base);
        write_reg(REG_FRAME_COUNT, C_FRAME_W'(frames));
        write_reg(REG_INFO_FRAME, info);
        cfg_ch.valid <= 1'b0;
        pool_base   = base;
        pool_frames = (frames > C_MAP_FRAMES) ? C_MAP_FRAMES : int'(frames);
        settings++;
    endtask

    // Keep valid high across back-to-back beats; drop it only for a gap.
    task automatic send_req(t_kind kind, logic [C_FRAME_W-1:0] frame,
                            logic [C_COUNT_W-1:0] count);
        int gap;
        gap = pick_wait(sent_total);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.frame <= frame;
        req_ch.count <= count;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent_total++;
        kind_sent[int'(kind)]++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : rsp_side
        int stall;
        int beats;
        beats = 0;
        forever begin
            // Hold off twice for a long stretch so the block backs up its input.
            if (beats == 400 || beats == 1000)
                stall = 600;
            else
                stall = pick_wait(beats);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            beats++;
        end
    end

    initial begin : stimulus
        logic [C_FRAME_W-1:0] base_pick;
        logic [C_COUNT_W-1:0] frames_pick;
        logic [C_FRAME_W-1:0] info_pick;
        logic [C_FRAME_W-1:0] r_frame;
        logic [C_COUNT_W-1:0] r_count;
        int                   roll;
        int                   span;

        sent_total = 0;
        settings   = 0;
        foreach (kind_sent[k])
            kind_sent[k] = 0;
        i_rst_n      <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_BASE_FRAME;
        cfg_ch.data  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_INIT;
        req_ch.frame <= '0;
        req_ch.count <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small pool; use before init, clipping at both ends, releases at the edges.
        configure(20'h00100, 11'd40, 20'h00000, 1'b1);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_MARK,    20'h000FC, 11'd6);
        send_req(KIND_INIT,    20'h00000, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_RELEASE, 20'h00101, 11'd0);
        send_req(KIND_RELEASE, 20'h000FF, 11'd0);
        send_req(KIND_RELEASE, 20'h00128, 11'd0);
        send_req(KIND_RELEASE, 20'h00127, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_MARK,    20'h00120, 11'd20);
        send_req(KIND_MARK,    20'h00110, 11'd0);
        send_req(KIND_MARK,    20'hFFFFF, 11'd1024);
        send_req(KIND_RELEASE, 20'hFFFFF, 11'd0);
        drain();

        // Oversized count clamps to the map; frame numbers wrap past the top.
        configure(20'hFFFFE, 11'd2047, 20'hFFFFF, 1'b0);
        send_req(KIND_INIT,    20'h00000, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_RELEASE, 20'h00000, 11'd0);
        send_req(KIND_MARK,    20'h00000, 11'd1024);
        drain();

        // Management frame outside the pool, then run the pool dry.
        configure(20'h00000, 11'd3, 20'h00005, 1'b0);
        send_req(KIND_INIT,    20'h00000, 11'd0);
        repeat (4) send_req(KIND_ALLOC, 20'h00000, 11'd0);
        send_req(KIND_MARK,    20'h00000, 11'd1);
        drain();

        // Empty pool.
        configure(20'h00000, 11'd0, 20'h00000, 1'b0);
        send_req(KIND_INIT,    20'h00000, 11'd0);
        send_req(KIND_ALLOC,   20'h00000, 11'd0);
        send_req(KIND_RELEASE, 20'h00000, 11'd0);
        drain();

        for (int p = 0; p < C_RANDOM_PHASES; p++) begin
            base_pick   = C_FRAME_W'($urandom_range(0, 20'hFFFFF));
            frames_pick = 11'd1024;
            info_pick   = '0;
            case (p)
                1: begin
                    frames_pick = C_COUNT_W'($urandom_range(1, 40));
                    info_pick   = C_FRAME_W'(base_pick + $urandom_range(0, frames_pick - 1));
                end
                2: begin
                    base_pick   = '0;
                    frames_pick = C_COUNT_W'($urandom_range(1, 1024));
                    info_pick   = C_FRAME_W'($urandom_range(0, 20'hFFFFF));
                end
                3: frames_pick = 11'd2047;
                4: begin
                    base_pick = 20'hFFC00;
                    info_pick = 20'hFFFFF;
                end
                5: begin
                    base_pick   = 20'hFFFFF;
                    frames_pick = C_COUNT_W'($urandom_range(1, 64));
                end
                default: ;
            endcase
            configure(base_pick, frames_pick, info_pick, 1'b0);
            send_req(KIND_INIT, '0, '0);
            span = (pool_frames == 0) ? 0 : pool_frames - 1;
            repeat (C_PHASE_ITEMS - 1) begin
                roll    = $urandom_range(0, 99);
                r_frame = C_FRAME_W'($urandom_range(0, 20'hFFFFF));
                r_count = C_COUNT_W'($urandom_range(0, 1024));
                if (roll < 4) begin
                    send_req(KIND_INIT, r_frame, r_count);
                end else if (roll < 45) begin
                    send_req(KIND_ALLOC, r_frame, r_count);
                end else if (roll < 70) begin
                    if ($urandom_range(0, 9) == 0)
                        r_frame = $urandom_range(0, 1) ? C_FRAME_W'(pool_base - 1)
                                                       : C_FRAME_W'(pool_base + pool_frames);
                    else
                        r_frame = C_FRAME_W'(pool_base + $urandom_range(0, span));
                    send_req(KIND_RELEASE, r_frame, r_count);
                end else if (roll < 85) begin
                    r_frame = C_FRAME_W'(pool_base + $urandom_range(0, pool_frames + 8) - 4);
                    if ($urandom_range(0, 3) != 0)
                        r_count = C_COUNT_W'($urandom_range(0, 40));
                    send_req(KIND_MARK, r_frame, r_count);
                end else begin
                    send_req(t_kind'($urandom_range(0, 3)), r_frame, r_count);
                end
            end
            drain();
        end

        // Let anything stray surface before the verdict.
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests (%0d init, %0d allocate, %0d release, %0d mark)",
                 sent_total, kind_sent[0], kind_sent[1], kind_sent[2], kind_sent[3]);
        $display("over %0d register settings; %0d result beats compared", settings, checked);
        if (errors == 0)
            $display("bitmap_frame_allocator_top regression: pass");
        else
            $display("bitmap_frame_allocator_top regression: fail");
        $finish;
    end

endmodule
